/* rtl/core/prt_pkg.sv */
// shared types and constants for the probe round-trip tracker
`default_nettype none
package prt_pkg;
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [31:0] TRIP_NONE = 32'hffff_ffff;
  localparam logic [4:0] MAX_PENDING_RST = 5'd16;
  localparam logic [0:0] REG_MAX_PENDING = 1'b0;

  localparam logic [2:0] OP_SEND  = 3'd0;
  localparam logic [2:0] OP_ACK   = 3'd1;
  localparam logic [2:0] OP_ACK1  = 3'd2;
  localparam logic [2:0] OP_CHECK = 3'd3;
  localparam logic [2:0] OP_DROP  = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [31:0] now_ms;
  } prt_in_t;

  typedef struct packed {
    logic        flag;
    logic [31:0] last_trip;
    logic [31:0] avg_trip;
    logic [31:0] min_trip;
    logic [31:0] max_trip;
    logic [4:0]  pending;
    logic [31:0] since_send;
  } prt_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture request
    logic scan_rd;   // read entry at scan index
    logic scan_clr;  // restart scan index at the oldest entry
    logic append;    // write new entry at count
    logic measure;   // update trip stats from captured time
    logic shift_rd;  // read entry at shift source
    logic shift_wr;  // write shifted entry
    logic set_cnt;   // apply count change
    logic emit;      // build result
  } prt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] opcode;
    logic       hit;       // scanned entry matches
    logic       scan_last; // scan index is at count-1
    logic       empty;
    logic       can_send;
    logic       shift_done;
  } prt_sts_t;
endpackage
`default_nettype wire

/* rtl/core/prt_dp.sv */
// datapath: entry memory, scan and shift indexes, trip statistics
`default_nettype none
module prt_dp
  import prt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire prt_in_t  req,
  input  wire prt_cmd_t cmd,
  input  wire logic     ctl_hit_set,  // record hit at current scan index
  input  wire logic     ctl_ack1_miss, // ack first miss: use oldest
  input  wire logic     ctl_remove_one, // remove only hit entry
  input  wire logic     ctl_flag,
  input  wire logic [4:0] max_pending,
  output prt_sts_t      sts,
  output prt_out_t      res
);
  logic [127+32:0] mem [DEPTH];
  prt_in_t req_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] scan_r, src_r, dst_r;
  logic [159:0] rd_r;
  logic rd_v_r;
  logic [31:0] last_r, avg_r, min_r, max_r, lsend_r;
  logic [31:0] delay, avg_b;
  logic [CNT_W-1:0] newcnt_r;
  logic flag_o_r;
  logic [4:0] pend_r;
  logic [31:0] since_r;

  // entry read and write
  always_ff @(posedge clk) begin
    if (cmd.append)
      mem[cnt_r[IDX_W-1:0]] <= {req_r.id_high, req_r.id_low, req_r.now_ms};
    if (cmd.shift_wr)
      mem[dst_r[IDX_W-1:0]] <= rd_r;
    if (cmd.scan_rd)
      rd_r <= mem[scan_r[IDX_W-1:0]];
    else if (cmd.shift_rd)
      rd_r <= mem[src_r[IDX_W-1:0]];
  end

  assign delay = req_r.now_ms - rd_r[31:0];
  assign avg_b = (delay < min_r && min_r == TRIP_NONE) ? delay : avg_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; last_r <= '0; avg_r <= '0; min_r <= TRIP_NONE;
      max_r <= '0; lsend_r <= '0; scan_r <= '0; rd_v_r <= 1'b0;
      src_r <= '0; dst_r <= '0; newcnt_r <= '0;
      flag_o_r <= 1'b0; pend_r <= '0; since_r <= '0;
    end else begin
      rd_v_r <= cmd.scan_rd;
      if (cmd.load) begin
        req_r  <= req;
        scan_r <= '0;
      end else if (rd_v_r && !cmd.scan_rd) begin
        scan_r <= scan_r;
      end else if (cmd.scan_rd) begin
        scan_r <= scan_r;
      end
      if (rd_v_r && !ctl_hit_set) scan_r <= scan_r + 1'b1;
      if (cmd.scan_clr) scan_r <= '0;
      if (ctl_hit_set || ctl_ack1_miss) begin
        if (ctl_remove_one) begin
          dst_r <= ctl_ack1_miss ? '0 : scan_r;
          src_r <= (ctl_ack1_miss ? '0 : scan_r) + 1'b1;
          newcnt_r <= cnt_r - 1'b1;
        end else begin
          dst_r <= '0;
          src_r <= (ctl_ack1_miss ? '0 : scan_r) + 1'b1;
          newcnt_r <= cnt_r - (ctl_ack1_miss ? CNT_W'(1) : scan_r + 1'b1);
        end
      end
      if (cmd.shift_wr) begin
        dst_r <= dst_r + 1'b1;
        src_r <= src_r + 1'b1;
      end
      if (cmd.append) begin
        cnt_r <= cnt_r + 1'b1;
        lsend_r <= req_r.now_ms;
      end
      if (cmd.set_cnt) cnt_r <= newcnt_r;
      if (cmd.measure) begin
        last_r <= delay;
        if (delay < min_r) min_r <= delay;
        if (delay > max_r) max_r <= delay;
        avg_r <= avg_b + (delay >> 2) - (avg_b >> 2);
      end
      if (cmd.emit) begin
        flag_o_r <= ctl_flag;
        pend_r   <= 5'(cnt_r);
        since_r  <= req_r.now_ms - lsend_r;
      end
    end
  end

  assign res.flag       = flag_o_r;
  assign res.pending    = pend_r;
  assign res.since_send = since_r;
  assign res.last_trip  = last_r;
  assign res.avg_trip   = avg_r;
  assign res.min_trip   = min_r;
  assign res.max_trip   = max_r;

  assign sts.opcode = req_r.opcode;
  assign sts.hit = rd_v_r && rd_r[159:32] == {req_r.id_high, req_r.id_low};
  assign sts.scan_last = (scan_r + 1'b1 == cnt_r);
  assign sts.empty = (cnt_r == '0);
  assign sts.can_send = (5'(cnt_r) < max_pending) && (cnt_r < CNT_W'(DEPTH));
  assign sts.shift_done = (src_r >= cnt_r);
endmodule
`default_nettype wire

/* rtl/core/prt_ctrl.sv */
// controller: sequences send, scan, measure, shift and result steps
`default_nettype none
module prt_ctrl
  import prt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire prt_sts_t sts,
  output prt_cmd_t      cmd,
  output logic          hit_set,
  output logic          ack1_miss,
  output logic          remove_one,
  output logic          flag
);
  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SCAN, S_CMP, S_CHKL, S_FIRST, S_MEAS, S_SRD, S_SWR,
    S_CNT, S_EMIT, S_OUT
  } st_t;
  st_t st_r;
  logic flag_r, oneonly_r, chk_r;

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign flag = flag_r;
  assign remove_one = oneonly_r;

  // command decode
  always_comb begin
    cmd = '0;
    hit_set = 1'b0;
    ack1_miss = 1'b0;
    cmd.load = (st_r == S_IDLE) && in_valid;
    cmd.scan_rd = (st_r == S_SCAN) || (st_r == S_FIRST);
    cmd.append = (st_r == S_DEC) && sts.opcode == OP_SEND && sts.can_send;
    cmd.measure = (st_r == S_MEAS);
    cmd.shift_rd = (st_r == S_SRD);
    cmd.shift_wr = (st_r == S_SWR);
    cmd.set_cnt = (st_r == S_CNT);
    cmd.emit = (st_r == S_EMIT);
    if (st_r == S_CMP) begin
      hit_set = sts.hit && !chk_r;
      ack1_miss = !sts.hit && sts.scan_last && sts.opcode == OP_ACK1;
    end
    // rescan after check send, or reread the oldest entry on ack first miss
    cmd.scan_clr = (st_r == S_CHKL) || ack1_miss;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; flag_r <= 1'b0; oneonly_r <= 1'b0; chk_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (in_valid) st_r <= S_DEC;
        S_DEC: begin
          flag_r <= 1'b0;
          oneonly_r <= (sts.opcode == OP_CHECK) || (sts.opcode == OP_DROP);
          chk_r <= 1'b0;
          case (sts.opcode)
            OP_SEND: begin
              flag_r <= sts.can_send;
              st_r <= S_EMIT;
            end
            OP_ACK, OP_ACK1, OP_DROP: st_r <= sts.empty ? S_EMIT : S_SCAN;
            OP_CHECK: begin
              chk_r <= 1'b1;
              st_r <= sts.empty ? S_EMIT : S_SCAN;
            end
            default: st_r <= S_EMIT;
          endcase
        end
        S_SCAN: st_r <= S_CMP;
        S_CMP: begin
          if (chk_r) begin
            // check send: newest entry first, then fall back to a drop scan
            if (sts.scan_last) begin
              if (sts.hit) begin
                flag_r <= 1'b1;
                st_r <= S_EMIT;
              end else st_r <= S_CHKL;
            end else st_r <= S_SCAN;
          end else if (sts.hit) begin
            flag_r <= (sts.opcode != OP_CHECK);
            st_r <= (sts.opcode == OP_ACK || sts.opcode == OP_ACK1) ? S_MEAS : S_SRD;
          end else if (sts.scan_last) begin
            if (sts.opcode == OP_ACK1) begin
              flag_r <= 1'b1;
              st_r <= S_FIRST;
            end else st_r <= S_EMIT;
          end else st_r <= S_SCAN;
        end
        S_CHKL: begin
          chk_r <= 1'b0;
          st_r <= S_SCAN;
        end
        S_FIRST: st_r <= S_MEAS;
        S_MEAS: st_r <= S_SRD;
        S_SRD: st_r <= sts.shift_done ? S_CNT : S_SWR;
        S_SWR: st_r <= S_SRD;
        S_CNT: st_r <= S_EMIT;
        S_EMIT: st_r <= S_OUT;
        S_OUT: if (out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/core/probe_rtt_tracker.sv */
// top level of the probe round-trip tracker
// One request at a time: a send, or any request on an empty table, goes
// straight from decode to the result. Ack, ack first, check send and drop
// scan the table oldest first through the single entry memory port, then
// shift the kept entries down. The worst request is a check send whose
// newest entry misses, which scans the table twice. Result is held on
// out_* until taken. max_pending sits at address 0 of the APB port.
`default_nettype none
module probe_rtt_tracker
  import prt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire prt_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output prt_out_t         out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:2]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  prt_cmd_t cmd;
  prt_sts_t sts;
  logic hit_set, ack1_miss, remove_one, flag;
  logic [4:0] maxp_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) maxp_r <= MAX_PENDING_RST;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_MAX_PENDING)
      maxp_r <= cfg_pwdata[4:0];
  end
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_MAX_PENDING) ? {27'd0, maxp_r} : 32'd0;

  prt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd,
    .hit_set, .ack1_miss, .remove_one, .flag
  );

  prt_dp u_dp (
    .clk, .rst_n, .req(in_data), .cmd, .ctl_hit_set(hit_set),
    .ctl_ack1_miss(ack1_miss), .ctl_remove_one(remove_one), .ctl_flag(flag),
    .max_pending(maxp_r), .sts, .res(out_data)
  );
endmodule
`default_nettype wire

/* test/probe_rtt_tracker_test.sv */
// testbench for the probe round-trip tracker: directed and random requests against a predictor
`timescale 1ns / 1ps
`default_nettype none
module probe_rtt_tracker_test;
  import prt_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS = 230;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  prt_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  prt_out_t    out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:2]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  probe_rtt_tracker dut (.*);

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // tracker model state
  logic [63:0] tbl_hi [DEPTH];
  logic [63:0] tbl_lo [DEPTH];
  logic [31:0] tbl_time [DEPTH];
  int unsigned tbl_count;
  logic [31:0] last_send_ms;
  logic [31:0] rtt_min, rtt_max, rtt_avg, rtt_last;
  int unsigned max_pending;

  prt_out_t    expected_results [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned flags_seen = 0;
  int unsigned idle_cycles = 0;
  logic [31:0] clock_ms = 32'd0;

  // round trip update against entry k
  task automatic take_trip(input int unsigned k, input logic [31:0] now);
    logic [31:0] delay;
    delay = now - tbl_time[k];
    rtt_last = delay;
    if (delay < rtt_min) begin
      if (rtt_min == TRIP_NONE) rtt_avg = delay;
      rtt_min = delay;
    end
    if (delay > rtt_max) rtt_max = delay;
    rtt_avg = rtt_avg + (delay >> 2) - (rtt_avg >> 2);
  endtask

  // remove entries [0, n)
  task automatic pop_front(input int unsigned n);
    for (int unsigned i = n; i < tbl_count; i++) begin
      tbl_hi[i - n] = tbl_hi[i];
      tbl_lo[i - n] = tbl_lo[i];
      tbl_time[i - n] = tbl_time[i];
    end
    tbl_count -= n;
  endtask

  // remove entry k
  task automatic pop_at(input int unsigned k);
    for (int unsigned i = k + 1; i < tbl_count; i++) begin
      tbl_hi[i - 1] = tbl_hi[i];
      tbl_lo[i - 1] = tbl_lo[i];
      tbl_time[i - 1] = tbl_time[i];
    end
    tbl_count--;
  endtask

  function automatic int find_probe(input logic [63:0] hi, input logic [63:0] lo);
    for (int unsigned i = 0; i < tbl_count; i++)
      if (tbl_hi[i] == hi && tbl_lo[i] == lo) return int'(i);
    return -1;
  endfunction

  // apply one request to the model and produce its expected result
  task automatic track_probe(input prt_in_t r, output prt_out_t o);
    logic flag;
    int   k;
    flag = 1'b0;
    k = find_probe(r.id_high, r.id_low);
    case (r.opcode)
      OP_SEND: begin
        if (tbl_count < max_pending && tbl_count < DEPTH) begin
          tbl_hi[tbl_count] = r.id_high;
          tbl_lo[tbl_count] = r.id_low;
          tbl_time[tbl_count] = r.now_ms;
          tbl_count++;
          last_send_ms = r.now_ms;
          flag = 1'b1;
        end
      end
      OP_ACK, OP_ACK1: begin
        if (k >= 0) begin
          take_trip(k, r.now_ms);
          pop_front(k + 1);
          flag = 1'b1;
        end else if (r.opcode == OP_ACK1 && tbl_count > 0) begin
          take_trip(0, r.now_ms);
          pop_front(1);
          flag = 1'b1;
        end
      end
      OP_CHECK: begin
        if (tbl_count > 0 && tbl_hi[tbl_count - 1] == r.id_high &&
            tbl_lo[tbl_count - 1] == r.id_low) begin
          flag = 1'b1;
        end else if (k >= 0) begin
          pop_at(k);
        end
      end
      OP_DROP: begin
        if (k >= 0) begin
          pop_at(k);
          flag = 1'b1;
        end
      end
      default: ;
    endcase
    o.flag = flag;
    o.last_trip = rtt_last;
    o.avg_trip = rtt_avg;
    o.min_trip = rtt_min;
    o.max_trip = rtt_max;
    o.pending = tbl_count[4:0];
    o.since_send = r.now_ms - last_send_ms;
  endtask

  task automatic note_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %s: expected %h, got %h", results_seen, name, e, a);
    end
  endtask

  // result checker, watchdog
  always @(posedge clk) begin
    prt_out_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("probe_rtt_tracker_test: done, errors");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with no request waiting: %p", out_data);
        end else begin
          want = expected_results.pop_front();
          note_field("flag", want.flag, out_data.flag);
          note_field("last_trip", want.last_trip, out_data.last_trip);
          note_field("avg_trip", want.avg_trip, out_data.avg_trip);
          note_field("min_trip", want.min_trip, out_data.min_trip);
          note_field("max_trip", want.max_trip, out_data.max_trip);
          note_field("pending", want.pending, out_data.pending);
          note_field("since_send", want.since_send, out_data.since_send);
          if (out_data.flag) flags_seen++;
        end
        results_seen++;
      end
    end
  end

  // receiver stalls
  always @(negedge clk)
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);

  // send one request, idling first at the sender's rate
  task automatic send_request(input prt_in_t r);
    prt_out_t o;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    track_probe(r, o);
    expected_results.push_back(o);
    requests_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // APB write of max_pending while idle
  task automatic write_max_pending(input int unsigned v);
    wait_drained();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= REG_MAX_PENDING;
    cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    max_pending = v & 5'h1f;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function automatic prt_in_t make_req(input logic [2:0] op, input logic [63:0] hi,
                                       input logic [63:0] lo, input logic [31:0] now);
    prt_in_t r;
    r.opcode = op;
    r.id_high = hi;
    r.id_low = lo;
    r.now_ms = now;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // extremes, every operation, misses, duplicates, full table
  task automatic test_directed();
    send_request(make_req(OP_ACK, '0, '0, 32'd5));
    send_request(make_req(OP_ACK1, '1, '1, 32'd6));
    send_request(make_req(OP_DROP, '0, '1, 32'd7));
    send_request(make_req(OP_CHECK, '1, '0, 32'd8));
    send_request(make_req(3'd7, '1, '1, '1));
    send_request(make_req(3'd5, '0, '0, '0));
    send_request(make_req(OP_SEND, '1, '1, 32'hffff_fff0));
    send_request(make_req(OP_SEND, '0, '0, 32'hffff_ffff));
    send_request(make_req(OP_SEND, '1, '1, 32'd20));
    // newest passes check send, then a check send on an older entry deletes it
    send_request(make_req(OP_CHECK, '1, '1, 32'd21));
    send_request(make_req(OP_CHECK, '0, '0, 32'd22));
    // wrap of time on ack
    send_request(make_req(OP_ACK, '1, '1, 32'd100));
    send_request(make_req(OP_ACK1, 64'h1234, 64'h5678, 32'd4000));
    send_request(make_req(OP_SEND, 64'haaaa_5555_aaaa_5555, 64'h5555_aaaa_5555_aaaa, 32'd5000));
    send_request(make_req(OP_SEND, 64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_aaaa_5555, 32'd5001));
    send_request(make_req(OP_DROP, 64'haaaa_5555_aaaa_5555, 64'h5555_aaaa_5555_aaaa, 32'd5002));
    send_request(make_req(OP_ACK1, 64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_aaaa_5555, '1));
    // table full at a limit of one entry
    write_max_pending(1);
    send_request(make_req(OP_SEND, 64'd1, 64'd1, 32'd6000));
    send_request(make_req(OP_SEND, 64'd2, 64'd2, 32'd6001));
    send_request(make_req(OP_ACK, 64'd1, 64'd1, 32'd6003));
    clock_ms = 32'd7000;
  endtask

  // random requests, mostly ids that hit the table
  task automatic test_random(input int unsigned n, input int unsigned s_idle,
                             input int unsigned r_idle);
    logic [2:0]  op;
    logic [63:0] hi, lo;
    int unsigned w, k;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int unsigned i = 0; i < n; i++) begin
      w = $urandom_range(99, 0);
      if (w < 36) op = OP_SEND;
      else if (w < 56) op = OP_ACK;
      else if (w < 68) op = OP_ACK1;
      else if (w < 82) op = OP_CHECK;
      else if (w < 96) op = OP_DROP;
      else op = 3'($urandom_range(7, 5));
      if (tbl_count > 0 && $urandom_range(3, 0) != 0) begin
        k = (op == OP_CHECK && $urandom_range(1, 0)) ? tbl_count - 1
                                                     : $urandom_range(tbl_count - 1, 0);
        hi = tbl_hi[k];
        lo = tbl_lo[k];
      end else begin
        hi = rand64();
        lo = rand64();
      end
      if ($urandom_range(19, 0) == 0) clock_ms = $urandom();
      else clock_ms += $urandom_range(3000, 0);
      send_request(make_req(op, hi, lo, clock_ms));
      // sender holds off until everything has come back
      if ($urandom_range(49, 0) == 0) wait_drained();
    end
  endtask

  initial begin
    rtt_min = TRIP_NONE;
    rtt_max = '0;
    rtt_avg = '0;
    rtt_last = '0;
    tbl_count = 0;
    last_send_ms = '0;
    max_pending = MAX_PENDING_RST;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    write_max_pending(16);
    test_random(PHASE_ITEMS, 19, 72);
    write_max_pending(4);
    test_random(PHASE_ITEMS / 2, 72, 19);
    write_max_pending($urandom_range(15, 2));
    test_random(PHASE_ITEMS / 2, 72, 19);
    write_max_pending(16);
    test_random(PHASE_ITEMS, 0, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d with flag set", requests_sent,
             results_seen, flags_seen);
    $display("max_pending settings 1, 4, random, 16; three idle mixes; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("probe_rtt_tracker_test: done, clean");
    end else begin
      $display("probe_rtt_tracker_test: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
